@@ hw/rtl/game_pad_poll_sequencer_defines.svh @@
// Assertion helpers for the checker file.
`ifndef GAME_PAD_POLL_SEQUENCER_DEFINES_SVH
`define GAME_PAD_POLL_SEQUENCER_DEFINES_SVH

// Same-cycle implication, sampled on aclk, quiet during reset.
`define GPS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("gps: same-cycle check failed");

// Next-cycle implication, sampled on aclk, quiet during reset.
`define GPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("gps: next-cycle check failed");

`endif

@@ hw/rtl/gps_pkg.sv @@
`default_nettype none

package gps_pkg;

    // Response and request shape
    localparam int MAX_RESPONSE   = 8;
    localparam int REQUEST_LENGTH = 4;
    localparam int CFG_COUNT      = 4;
    localparam int CONNECT_MIN    = 4;
    localparam int BUTTON_LO_IDX  = 2;
    localparam int BUTTON_HI_IDX  = 3;

    localparam int COUNT_W = $clog2(MAX_RESPONSE + 1);
    localparam int LEN_W   = 4;
    localparam int LEN_MAX = (1 << LEN_W) - 1;

    localparam logic [7:0]  ADDRESS_BYTE     = 8'h01;
    localparam logic [7:0]  POLL_CMD_RESET   = 8'h42;
    localparam logic [15:0] BUTTON_MASK      = 16'hFFFF;

    // Opcodes
    localparam logic OP_START     = 1'b0;
    localparam logic OP_BYTE_DONE = 1'b1;

    // Poll phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ADDR = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;

    // Register indexes
    localparam logic [1:0] CFG_POLL_COMMAND     = 2'd0;
    localparam logic [1:0] CFG_MULTITAP_ADDRESS = 2'd1;
    localparam logic [1:0] CFG_MOTOR_SMALL      = 2'd2;
    localparam logic [1:0] CFG_MOTOR_LARGE      = 2'd3;

    typedef struct packed {
        logic       opcode;
        logic       port;
        logic [7:0] rx_byte;
        logic       ack;
    } in_item_t;

    typedef struct packed {
        logic             select_port;
        logic             select_active;
        logic             send_valid;
        logic [7:0]       tx_byte;
        logic             done_res;
        logic             connected;
        logic [LEN_W-1:0] response_length;
        logic [15:0]      buttons;
        logic [15:0]      newly_pressed;
    } out_item_t;

    typedef struct packed {
        logic [7:0] poll_command;
        logic [7:0] multitap_address;
        logic [7:0] motor_small;
        logic [7:0] motor_large;
    } cfg_t;

    // Request byte for a given position after the address byte; zero past the end.
    function automatic logic [7:0] request_byte(input cfg_t cfg,
                                                input logic [COUNT_W-1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        if (int'(idx) < REQUEST_LENGTH && int'(idx) < CFG_COUNT) begin
            unique case (idx[1:0])
                CFG_POLL_COMMAND:     b = cfg.poll_command;
                CFG_MULTITAP_ADDRESS: b = cfg.multitap_address;
                CFG_MOTOR_SMALL:      b = cfg.motor_small;
                CFG_MOTOR_LARGE:      b = cfg.motor_large;
            endcase
        end
        return b;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/gps_cfg_regs.sv @@
`default_nettype none

module gps_cfg_regs
    import gps_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_wdata,
    output cfg_t            cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.poll_command     <= POLL_CMD_RESET;
            cfg_reg.multitap_address <= 8'h00;
            cfg_reg.motor_small      <= 8'h00;
            cfg_reg.motor_large      <= 8'h00;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_POLL_COMMAND:     cfg_reg.poll_command     <= cfg_wdata;
                CFG_MULTITAP_ADDRESS: cfg_reg.multitap_address <= cfg_wdata;
                CFG_MOTOR_SMALL:      cfg_reg.motor_small      <= cfg_wdata;
                CFG_MOTOR_LARGE:      cfg_reg.motor_large      <= cfg_wdata;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ hw/rtl/gps_core.sv @@
`default_nettype none

module gps_core
    import gps_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     step,
    input  wire in_item_t item,
    input  wire cfg_t     cfg,
    output out_item_t     result
);

    logic               active_port_reg, active_port_next;
    logic [1:0]         phase_reg, phase_next;
    logic [COUNT_W-1:0] count_reg, count_next, count_inc;
    logic [15:0]        raw_reg  [2];
    logic [15:0]        prev_reg [2];
    logic               conn_reg [2];

    // One port is touched per request, so one address serves every per-port store.
    logic        sel;
    logic [15:0] raw_sel, prev_sel, raw_wr, prev_wr, btn;
    logic        conn_sel, conn_wr, finish;

    always_comb begin
        sel      = (item.opcode == OP_START) ? item.port : active_port_reg;
        raw_sel  = raw_reg[sel];
        prev_sel = prev_reg[sel];
        conn_sel = conn_reg[sel];

        active_port_next = sel;
        phase_next       = phase_reg;
        count_next       = count_reg;
        count_inc        = COUNT_W'(int'(count_reg) + 1);
        raw_wr           = raw_sel;
        prev_wr          = prev_sel;
        conn_wr          = conn_sel;
        finish           = 1'b0;
        btn              = 16'h0000;
        result           = '0;

        if (item.opcode == OP_START) begin
            prev_wr              = raw_sel;
            count_next           = '0;
            phase_next           = PH_ADDR;
            result.select_active = 1'b1;
            result.send_valid    = 1'b1;
            result.tx_byte       = ADDRESS_BYTE;
        end else begin
            unique case (phase_reg)
                PH_ADDR: begin
                    if (!item.ack) begin
                        finish = 1'b1;
                    end else begin
                        phase_next           = PH_DATA;
                        result.select_active = 1'b1;
                        result.send_valid    = 1'b1;
                        result.tx_byte       = request_byte(cfg, '0);
                    end
                end
                PH_DATA: begin
                    if (int'(count_reg) == BUTTON_LO_IDX) begin
                        raw_wr = {raw_sel[15:8], item.rx_byte};
                    end else if (int'(count_reg) == BUTTON_HI_IDX) begin
                        raw_wr = {item.rx_byte, raw_sel[7:0]};
                    end
                    count_next = count_inc;
                    if (!item.ack || int'(count_inc) >= MAX_RESPONSE) begin
                        finish = 1'b1;
                    end else begin
                        result.select_active = 1'b1;
                        result.send_valid    = 1'b1;
                        result.tx_byte       = request_byte(cfg, count_inc);
                    end
                end
                default: begin
                    // idle: byte-done is a plain status report
                end
            endcase
        end

        if (finish) begin
            conn_wr         = int'(count_next) >= CONNECT_MIN;
            phase_next      = PH_IDLE;
            result.done_res = 1'b1;
            if (conn_wr) begin
                btn                  = raw_wr ^ BUTTON_MASK;
                result.buttons       = btn;
                result.newly_pressed = btn & prev_sel;
            end
        end

        result.select_port     = sel;
        result.connected       = conn_wr;
        result.response_length = (int'(count_next) > LEN_MAX) ? LEN_W'(LEN_MAX)
                                                              : LEN_W'(count_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_port_reg <= 1'b0;
            phase_reg       <= PH_IDLE;
            count_reg       <= '0;
            for (int i = 0; i < 2; i++) begin
                raw_reg[i]  <= 16'h0000;
                prev_reg[i] <= 16'h0000;
                conn_reg[i] <= 1'b0;
            end
        end else if (step) begin
            active_port_reg <= active_port_next;
            phase_reg       <= phase_next;
            count_reg       <= count_next;
            raw_reg[sel]    <= raw_wr;
            prev_reg[sel]   <= prev_wr;
            conn_reg[sel]   <= conn_wr;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/game_pad_poll_sequencer.sv @@
// A request accepted on s_ is held in the input stage, then in the result stage, before it shows on m_.
// Throughput: one request per cycle while m_ is not stalled; the poll state updates in a single pass between stages.
// A stalled m_ side holds the result stage, and the input stage takes one more request.
// Reset (aresetn low, synchronous): both stages empty, poll idle, button words and
// connection flags cleared, poll_command back to 0x42 and the other registers to 0.
`default_nettype none

module game_pad_poll_sequencer
    import gps_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,

    // request channel
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire in_item_t   s_data,

    // result channel
    output logic            m_valid,
    input  wire logic       m_ready,
    output out_item_t       m_data,

    // configuration write port
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_wdata
);

    cfg_t      cfg;
    in_item_t  in_data_reg;
    logic      in_valid_reg;
    out_item_t out_data_reg;
    logic      out_valid_reg;
    out_item_t core_result;
    logic      advance;

    // Advance the held request into the result stage whenever that stage is free
    // or is being emptied this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);

    // Take a new request while the input stage is empty or moving on.
    assign s_ready = !in_valid_reg || advance;

    gps_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Poll sequencing and per-port button tracking; state commits only on advance.
    gps_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_data_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    // Input stage: valid bit is control, the payload needs no reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    // Result stage: load on advance, drop once taken downstream.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= core_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire

@@ hw/rtl/gps_checker.sv @@
`default_nettype none

`include "game_pad_poll_sequencer_defines.svh"

module gps_checker
    import gps_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_data
);

    `GPS_ASSERT_NEXT(a_hold_stalled, m_valid && !m_ready, m_valid && $stable(m_data))
    `GPS_ASSERT_NOW(a_done_no_send, m_valid && m_data.done_res,
                    !m_data.send_valid && !m_data.select_active)
    `GPS_ASSERT_NOW(a_idle_tx_zero, m_valid && !m_data.send_valid, m_data.tx_byte == 8'h00)
    `GPS_ASSERT_NOW(a_unconn_blank, m_valid && (!m_data.connected || !m_data.done_res),
                    m_data.buttons == 16'h0000 && m_data.newly_pressed == 16'h0000)
    `GPS_ASSERT_NOW(a_len_bound, m_valid, int'(m_data.response_length) <= MAX_RESPONSE)

endmodule

bind game_pad_poll_sequencer gps_checker u_gps_checker (.*);

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import gps_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 4;
    localparam int TAIL_CYCLES  = 10;
    localparam int MAX_SHOWN    = 10;

    // Receiver behaviour, switched at random intervals
    localparam int RX_FREE = 0;
    localparam int RX_COIN = 1;
    localparam int RX_SLOW = 2;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    in_item_t   s_data    = '0;
    logic       m_ready   = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_wdata = '0;
    logic       s_ready;
    logic       m_valid;
    out_item_t  m_data;

    game_pad_poll_sequencer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow of the poll state and the request registers, as left by reset
    logic [7:0]  req_regs [CFG_COUNT] = '{POLL_CMD_RESET, 8'h00, 8'h00, 8'h00};
    logic        poll_port  = 1'b0;
    logic [1:0]  poll_phase = PH_IDLE;
    int          rx_count   = 0;
    logic [15:0] raw_word  [2] = '{default: '0};
    logic [15:0] prev_word [2] = '{default: '0};
    logic        port_live [2] = '{default: 1'b0};

    // Status words still owed by the block, oldest first
    out_item_t pending_status [$];

    int bad_fields  = 0;
    int poll_items  = 0;
    int cycle_count = 0;
    int burst_left  = 0;
    int hold_asked  = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int rx_mode     = RX_FREE;
    int mode_left   = 0;

    always #HALF_PERIOD aclk = ~aclk;

    // Watchdog: give up well beyond the slowest legal run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Byte sent after the address byte at a given position; padding past the registers
    function automatic logic [7:0] request_tx(input int pos);
        if (pos < REQUEST_LENGTH && pos < CFG_COUNT)
            return req_regs[pos];
        return 8'h00;
    endfunction

    // Advance the shadow poll by one accepted request and return the status it causes
    function automatic out_item_t predict_poll(input in_item_t req);
        out_item_t st;
        logic      ending;
        st = '0;
        ending = 1'b0;
        if (req.opcode == OP_START) begin
            // a start always wins, even over a poll in flight
            poll_port = req.port;
            prev_word[req.port] = raw_word[req.port];
            rx_count = 0;
            poll_phase = PH_ADDR;
            st.select_active = 1'b1;
            st.send_valid = 1'b1;
            st.tx_byte = ADDRESS_BYTE;
        end else if (poll_phase == PH_ADDR) begin
            if (!req.ack) begin
                ending = 1'b1;
            end else begin
                poll_phase = PH_DATA;
                st.select_active = 1'b1;
                st.send_valid = 1'b1;
                st.tx_byte = request_tx(0);
            end
        end else if (poll_phase == PH_DATA) begin
            // only the two button bytes are kept
            if (rx_count == BUTTON_LO_IDX)
                raw_word[poll_port][7:0] = req.rx_byte;
            else if (rx_count == BUTTON_HI_IDX)
                raw_word[poll_port][15:8] = req.rx_byte;
            rx_count++;
            if (!req.ack || rx_count >= MAX_RESPONSE) begin
                ending = 1'b1;
            end else begin
                st.select_active = 1'b1;
                st.send_valid = 1'b1;
                st.tx_byte = request_tx(rx_count);
            end
        end
        if (ending) begin
            port_live[poll_port] = (rx_count >= CONNECT_MIN);
            poll_phase = PH_IDLE;
            st.done_res = 1'b1;
            if (port_live[poll_port]) begin
                // raw word is active low; newly pressed means released last time
                st.buttons = ~raw_word[poll_port];
                st.newly_pressed = st.buttons & prev_word[poll_port];
            end
        end
        st.select_port = poll_port;
        st.connected = port_live[poll_port];
        st.response_length = (rx_count > LEN_MAX) ? LEN_W'(LEN_MAX) : LEN_W'(rx_count);
        return st;
    endfunction

    function automatic in_item_t mk_req(input logic op, input logic port,
                                        input logic [7:0] rx, input logic ack);
        in_item_t req;
        req.opcode = op;
        req.port = port;
        req.rx_byte = rx;
        req.ack = ack;
        return req;
    endfunction

    // Skew received bytes towards the all-zero and all-one patterns
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Offer one request from a falling edge, hold it until taken, then drop valid.
    // Bursts of random length are separated by random gaps, sometimes none.
    task automatic send_req(input in_item_t req);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
        burst_left--;
        s_data = req;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        // byte-done requests while idle leave the poll state alone: do not count them
        if (req.opcode == OP_START || poll_phase != PH_IDLE)
            poll_items++;
        pending_status.push_back(predict_poll(req));
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_index = idx;
        cfg_wdata = val;
        cfg_we = 1'b1;
        @(negedge aclk);
        cfg_we = 1'b0;
        req_regs[idx] = val;
    endtask

    // Wait until every owed status word has come back, plus a short margin
    task automatic settle_block();
        while (pending_status.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Mostly well-formed polls with random content; the rest is stray or random noise
    task automatic run_polls(input int n);
        int   target;
        int   len;
        int   roll;
        int   i;
        logic abandon;
        logic last_ack;
        target = poll_items + n;
        while (poll_items < target) begin
            roll = $urandom_range(0, 99);
            if (roll < 80) begin
                send_req(mk_req(OP_START, 1'($urandom), 8'($urandom), 1'($urandom)));
                if ($urandom_range(0, 9) == 0) begin
                    send_req(mk_req(OP_BYTE_DONE, 1'($urandom), rand_byte(), 1'b0));
                end else begin
                    send_req(mk_req(OP_BYTE_DONE, 1'($urandom), rand_byte(), 1'b1));
                    len = $urandom_range(1, MAX_RESPONSE);
                    // leave some polls hanging so that the next start cuts them off
                    abandon = ($urandom_range(0, 11) == 0);
                    for (i = 0; i < len; i++) begin
                        if (abandon || i < len - 1)
                            last_ack = 1'b1;
                        else
                            last_ack = (len == MAX_RESPONSE) ? 1'($urandom) : 1'b0;
                        send_req(mk_req(OP_BYTE_DONE, 1'($urandom), rand_byte(), last_ack));
                    end
                end
            end else if (roll < 90) begin
                send_req(mk_req(OP_BYTE_DONE, 1'($urandom), rand_byte(), 1'($urandom)));
            end else begin
                send_req(mk_req(1'($urandom), 1'($urandom), 8'($urandom), 1'($urandom)));
            end
        end
    endtask

    task automatic test_idle_byte_done();
        send_req(mk_req(OP_BYTE_DONE, 1'b1, 8'hFF, 1'b1));
        send_req(mk_req(OP_BYTE_DONE, 1'b0, 8'h00, 1'b0));
    endtask

    task automatic test_address_nack();
        send_req(mk_req(OP_START, 1'b1, 8'h00, 1'b1));
        send_req(mk_req(OP_BYTE_DONE, 1'b0, 8'hFF, 1'b0));
    endtask

    // Full-length poll with the registers at their reset values
    task automatic test_full_poll();
        send_req(mk_req(OP_START, 1'b0, 8'hFF, 1'b0));
        send_req(mk_req(OP_BYTE_DONE, 1'b1, 8'hFF, 1'b1));
        send_req(mk_req(OP_BYTE_DONE, 1'b0, 8'hFF, 1'b1));
        send_req(mk_req(OP_BYTE_DONE, 1'b0, 8'h5A, 1'b1));
        send_req(mk_req(OP_BYTE_DONE, 1'b0, 8'h00, 1'b1));
        send_req(mk_req(OP_BYTE_DONE, 1'b0, 8'hFF, 1'b1));
        send_req(mk_req(OP_BYTE_DONE, 1'b0, 8'hA5, 1'b1));
        send_req(mk_req(OP_BYTE_DONE, 1'b0, 8'h00, 1'b1));
        send_req(mk_req(OP_BYTE_DONE, 1'b0, 8'h3C, 1'b1));
        send_req(mk_req(OP_BYTE_DONE, 1'b0, 8'hC3, 1'b1));
    endtask

    // Start on port 1, cut it off with a start on port 0, end after exactly four bytes
    task automatic test_restart();
        send_req(mk_req(OP_START, 1'b1, 8'h00, 1'b0));
        send_req(mk_req(OP_BYTE_DONE, 1'b0, 8'h81, 1'b1));
        send_req(mk_req(OP_BYTE_DONE, 1'b0, 8'h18, 1'b1));
        send_req(mk_req(OP_START, 1'b0, 8'h00, 1'b0));
        send_req(mk_req(OP_BYTE_DONE, 1'b1, 8'h00, 1'b1));
        send_req(mk_req(OP_BYTE_DONE, 1'b1, 8'h00, 1'b1));
        send_req(mk_req(OP_BYTE_DONE, 1'b1, 8'hF0, 1'b1));
        send_req(mk_req(OP_BYTE_DONE, 1'b1, 8'h0F, 1'b1));
        send_req(mk_req(OP_BYTE_DONE, 1'b1, 8'h77, 1'b0));
    endtask

    // Three bytes only: low button byte updated, high byte kept, port dropped
    task automatic test_short_response();
        send_req(mk_req(OP_START, 1'b0, 8'h00, 1'b0));
        send_req(mk_req(OP_BYTE_DONE, 1'b0, 8'h00, 1'b1));
        send_req(mk_req(OP_BYTE_DONE, 1'b0, 8'h11, 1'b1));
        send_req(mk_req(OP_BYTE_DONE, 1'b0, 8'h22, 1'b1));
        send_req(mk_req(OP_BYTE_DONE, 1'b0, 8'h33, 1'b0));
    endtask

    // Hold the result side off for a long stretch while requests keep coming
    task automatic test_output_stall();
        hold_asked++;
        run_polls(40);
    endtask

    function automatic logic [7:0] phase_value(input int phase_no);
        case (phase_no)
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Several register settings, extremes first, each followed by random polls
    task automatic test_register_sweep();
        int k;
        for (k = 0; k < 6; k++) begin
            settle_block();
            write_reg(CFG_POLL_COMMAND, phase_value(k));
            write_reg(CFG_MULTITAP_ADDRESS, phase_value(k));
            write_reg(CFG_MOTOR_SMALL, phase_value(k));
            write_reg(CFG_MOTOR_LARGE, phase_value(k));
            run_polls(330);
        end
    endtask

    // Receiver: honour a long hold-off when asked, else stall on a changing pattern
    always @(negedge aclk) begin
        if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready = 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode = $urandom_range(RX_FREE, RX_SLOW);
                mode_left = $urandom_range(5, 60);
            end
            mode_left--;
            case (rx_mode)
                RX_FREE: m_ready = 1'b1;
                RX_COIN: m_ready = 1'($urandom);
                default: m_ready = ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            bad_fields++;
            if (bad_fields <= MAX_SHOWN)
                $display("status mismatch on %s: expected %h, got %h", field, want, got);
        end
    endtask

    // Compare every status word taken from the block with the oldest one owed
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_status.size() == 0) begin
                bad_fields++;
                if (bad_fields <= MAX_SHOWN)
                    $display("status word with none owed: %h", m_data);
            end else begin
                want = pending_status.pop_front();
                check_field("select_port", want.select_port, m_data.select_port);
                check_field("select_active", want.select_active, m_data.select_active);
                check_field("send_valid", want.send_valid, m_data.send_valid);
                check_field("tx_byte", want.tx_byte, m_data.tx_byte);
                check_field("done_res", want.done_res, m_data.done_res);
                check_field("connected", want.connected, m_data.connected);
                check_field("response_length", want.response_length,
                            m_data.response_length);
                check_field("buttons", want.buttons, m_data.buttons);
                check_field("newly_pressed", want.newly_pressed, m_data.newly_pressed);
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_idle_byte_done();
        test_address_nack();
        test_full_poll();
        test_restart();
        test_short_response();
        test_output_stall();
        test_register_sweep();

        // drain, then give the block time to show anything stray
        while (pending_status.size() != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (bad_fields == 0 && pending_status.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/gps_pkg.sv
hw/rtl/gps_cfg_regs.sv
hw/rtl/gps_core.sv
hw/rtl/game_pad_poll_sequencer.sv
hw/rtl/gps_checker.sv
tb/sv/testbench.sv
